@@ hw/rtl/m3inv_pkg.sv @@
// Shared widths, types and constants of the 3x3 matrix inverse.
package m3inv_pkg;

  localparam int EW = 32;              // Q16.16 element
  localparam int PW = 2 * EW;          // element product
  localparam int CW = PW + 1;          // cofactor
  localparam int DW = CW + EW;         // determinant and shifted numerator
  localparam int QB = EW + 1;          // quotient bits resolved by the divider
  localparam int SW = DW + QB;         // divider compare width
  localparam int NE = 9;               // elements per item

  localparam int COF_LAT  = 5;         // cofactor and determinant stages
  localparam int DIV_LAT  = QB + 3;    // two setup stages, one per bit, one saturate
  localparam int PIPE_LAT = COF_LAT + DIV_LAT;

  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef logic signed [DW-1:0] det_t;

  localparam logic [QB-1:0] QLIM_POS = QB'(33'h0_7FFF_FFFF);
  localparam logic [QB-1:0] QLIM_NEG = QB'(33'h0_8000_0000);
  localparam elem_t SAT_POS = 32'sh7FFF_FFFF;
  localparam elem_t SAT_NEG = 32'sh8000_0000;

  // Rows (or columns) left when one of three is removed.
  localparam int OTHER_A [3] = '{1, 0, 0};
  localparam int OTHER_B [3] = '{2, 2, 1};

endpackage

@@ hw/rtl/matrix3_inverse_top.sv @@
// Each item passes the cofactor stages, the divider lanes and the output register.
// Throughput: one item per cycle; nine divider lanes, one per inverse element,
// resolve one quotient bit per stage so a new matrix enters each unstalled cycle.
// A two-entry output buffer takes one more result while another waits to be taken.
// Reset clears the valid bits of the pipeline and the output buffer only.
module matrix3_inverse_top import m3inv_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  elem_t in_r0c0,
  input  elem_t in_r0c1,
  input  elem_t in_r0c2,
  input  elem_t in_r1c0,
  input  elem_t in_r1c1,
  input  elem_t in_r1c2,
  input  elem_t in_r2c0,
  input  elem_t in_r2c1,
  input  elem_t in_r2c2,
  output logic  out_valid,
  input  logic  out_ready,
  output elem_t out_inv_r0c0,
  output elem_t out_inv_r0c1,
  output elem_t out_inv_r0c2,
  output elem_t out_inv_r1c0,
  output elem_t out_inv_r1c1,
  output elem_t out_inv_r1c2,
  output elem_t out_inv_r2c0,
  output elem_t out_inv_r2c1,
  output elem_t out_inv_r2c2,
  output logic  out_singular
);

  elem_t mat [NE];
  cof_t  cof [NE];
  det_t  det;
  elem_t lane_res [NE];
  elem_t res_c [NE];
  logic  en;
  logic  push;

  logic [PIPE_LAT-1:0] vld_r;
  logic [DIV_LAT-1:0]  sing_r;
  logic                out_valid_r;
  logic                spr_valid_r;
  elem_t               out_d_r [NE];
  elem_t               spr_d_r [NE];
  logic                out_sing_r;
  logic                spr_sing_r;

  assign mat = '{in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                 in_r2c0, in_r2c1, in_r2c2};

  // The pipeline only stalls once the spare output entry is occupied.
  assign en       = !spr_valid_r;
  assign in_ready = en;
  assign push     = en && vld_r[PIPE_LAT-1];

  m3inv_cofdet u_cofdet (
    .clk (clk),
    .en  (en),
    .mat (mat),
    .cof (cof),
    .det (det)
  );

  for (genvar k = 0; k < NE; k++) begin : g_lane
    // The adjugate is the transposed cofactor matrix.
    m3inv_div_lane u_lane (
      .clk (clk),
      .en  (en),
      .adj (cof[(k % 3) * 3 + k / 3]),
      .det (det),
      .res (lane_res[k])
    );
    assign res_c[k] = sing_r[DIV_LAT-1] ? '0 : lane_res[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing_r <= {sing_r[DIV_LAT-2:0], (det == '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      spr_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (spr_valid_r) begin
        out_valid_r <= 1'b1;
        spr_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      spr_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (spr_valid_r) begin
        out_d_r    <= spr_d_r;
        out_sing_r <= spr_sing_r;
      end else begin
        out_d_r    <= res_c;
        out_sing_r <= sing_r[DIV_LAT-1];
      end
    end else if (push) begin
      spr_d_r    <= res_c;
      spr_sing_r <= sing_r[DIV_LAT-1];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_inv_r0c0 = out_d_r[0];
  assign out_inv_r0c1 = out_d_r[1];
  assign out_inv_r0c2 = out_d_r[2];
  assign out_inv_r1c0 = out_d_r[3];
  assign out_inv_r1c1 = out_d_r[4];
  assign out_inv_r1c2 = out_d_r[5];
  assign out_inv_r2c0 = out_d_r[6];
  assign out_inv_r2c1 = out_d_r[7];
  assign out_inv_r2c2 = out_d_r[8];
  assign out_singular = out_sing_r;

  a_spare_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    spr_valid_r |-> out_valid_r)
    else $error("spare output entry held while the main entry is empty");

  a_spare_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(spr_valid_r) |-> $past(out_valid_r && !out_ready))
    else $error("spare output entry filled without a stalled result");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sing_r) |-> (out_d_r[0] == '0 && out_d_r[4] == '0 &&
                                     out_d_r[8] == '0))
    else $error("singular item carries non-zero elements");

endmodule

@@ hw/rtl/m3inv_cofdet.sv @@
// Cofactor and determinant pipeline for one 3x3 matrix per cycle while en is high.
module m3inv_cofdet import m3inv_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  elem_t mat [NE],
  output cof_t  cof [NE],
  output det_t  det
);

  prod_t p_c [NE];
  prod_t s_c [NE];
  prod_t p_r [NE];
  prod_t s_r [NE];
  elem_t row_a_r [3];
  elem_t row_b_r [3];
  cof_t  cof_b_c [NE];
  cof_t  cof_b_r [NE];
  cof_t  cof_c_r [NE];
  cof_t  cof_d_r [NE];
  cof_t  cof_e_r [NE];
  cof_t  pl_c [3];
  cof_t  ph_c [3];
  cof_t  pl_r [3];
  cof_t  ph_r [3];
  det_t  term_r [3];
  det_t  det_r;

  for (genvar k = 0; k < NE; k++) begin : g_cof
    localparam int R  = k / 3;
    localparam int C  = k % 3;
    localparam int R1 = OTHER_A[R];
    localparam int R2 = OTHER_B[R];
    localparam int C1 = OTHER_A[C];
    localparam int C2 = OTHER_B[C];
    cof_t v;
    assign p_c[k] = mat[R1*3+C1] * mat[R2*3+C2];
    assign s_c[k] = mat[R1*3+C2] * mat[R2*3+C1];
    assign v = cof_t'(p_r[k]) - cof_t'(s_r[k]);
    // Checkerboard sign: odd row plus column positions are negated.
    assign cof_b_c[k] = (((R + C) % 2) == 1) ? -v : v;
  end

  for (genvar j = 0; j < 3; j++) begin : g_det
    logic signed [EW:0] lo;
    logic signed [EW:0] hi;
    // Split the cofactor so each product stays near 32 by 32 bits.
    assign lo = $signed({1'b0, cof_b_r[j][EW-1:0]});
    assign hi = cof_b_r[j][CW-1:EW];
    assign pl_c[j] = row_b_r[j] * lo;
    assign ph_c[j] = row_b_r[j] * hi;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NE; k++) begin
        p_r[k]     <= p_c[k];
        s_r[k]     <= s_c[k];
        cof_b_r[k] <= cof_b_c[k];
        cof_c_r[k] <= cof_b_r[k];
        cof_d_r[k] <= cof_c_r[k];
        cof_e_r[k] <= cof_d_r[k];
      end
      for (int j = 0; j < 3; j++) begin
        row_a_r[j] <= mat[j];
        row_b_r[j] <= row_a_r[j];
        pl_r[j]    <= pl_c[j];
        ph_r[j]    <= ph_c[j];
        term_r[j]  <= (det_t'(ph_r[j]) <<< EW) + det_t'(pl_r[j]);
      end
      det_r <= term_r[0] + term_r[1] + term_r[2];
    end
  end

  assign cof = cof_e_r;
  assign det = det_r;

endmodule

@@ hw/rtl/m3inv_div_lane.sv @@
// One divider lane: adjugate entry shifted by 32 over the determinant, saturated.
module m3inv_div_lane import m3inv_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  cof_t  adj,
  input  det_t  det,
  output elem_t res
);

  logic [DW-1:0] num_a_r;
  logic [DW-1:0] den_a_r;
  logic          neg_a_r;
  logic [CW-1:0] adj_abs;

  logic [DW-1:0] rem_r [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic [DW-1:0] den_r [QB+1];
  logic          neg_r [QB+1];
  logic          ovf_r [QB+1];

  logic [DW-1:0] rem_c [QB];
  logic [QB-1:0] q_c   [QB];
  logic          sat;
  elem_t         res_r;

  assign adj_abs = adj[CW-1] ? CW'(-adj) : CW'(adj);

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int BIT = QB - 1 - k;
    logic [SW:0] diff;
    assign diff = {1'b0, SW'(rem_r[k])} - ({1'b0, SW'(den_r[k])} << BIT);
    always_comb begin
      rem_c[k] = rem_r[k];
      q_c[k]   = q_r[k];
      if (!diff[SW]) begin
        rem_c[k]    = diff[DW-1:0];
        q_c[k][BIT] = 1'b1;
      end
    end
  end

  assign sat = ovf_r[QB] || (neg_r[QB] ? (q_r[QB] > QLIM_NEG) : (q_r[QB] > QLIM_POS));

  always_ff @(posedge clk) begin
    if (en) begin
      num_a_r <= {adj_abs, {EW{1'b0}}};
      den_a_r <= det[DW-1] ? DW'(-det) : DW'(det);
      neg_a_r <= adj[CW-1] ^ det[DW-1];
      // A quotient of 2^33 or more saturates whatever its low bits are.
      rem_r[0] <= num_a_r;
      q_r[0]   <= '0;
      den_r[0] <= den_a_r;
      neg_r[0] <= neg_a_r;
      ovf_r[0] <= {{QB{1'b0}}, num_a_r} >= {den_a_r, {QB{1'b0}}};
      for (int k = 0; k < QB; k++) begin
        rem_r[k+1] <= rem_c[k];
        q_r[k+1]   <= q_c[k];
        den_r[k+1] <= den_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
      if (sat) begin
        res_r <= neg_r[QB] ? SAT_NEG : SAT_POS;
      end else begin
        res_r <= neg_r[QB] ? EW'(-q_r[QB]) : q_r[QB][EW-1:0];
      end
    end
  end

  assign res = res_r;

endmodule
